// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define MWCV_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define MWCV_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/mwcv_pkg.sv =====
// Package with sizes, item types and back-end states of the covering-window block.
`default_nettype none
package mwcv_pkg;

    localparam int MAX_COVER    = 128;
    localparam int WINDOW_DEPTH = 4096;

    localparam int VALUE_W = 16;
    localparam int K_W     = 8;
    localparam int IDX_W   = $clog2(MAX_COVER);
    localparam int PTR_W   = $clog2(WINDOW_DEPTH);
    localparam int OCC_W   = PTR_W + 1;
    localparam int CNT_W   = OCC_W;
    localparam int OUT_W   = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One window entry: whether the value counts, and its slot in the count table.
    typedef struct packed {
        logic             in_range;
        logic [IDX_W-1:0] idx;
    } win_entry_t;

    // One classified input item as it travels through the queue.
    typedef struct packed {
        logic       last;
        win_entry_t entry;
    } item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_RD,
        S_POP_CNT,
        S_POP_WR,
        S_PUSH,
        S_PUSH_WR,
        S_CHECK,
        S_REPORT
    } back_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/min_window_covering_values.sv =====
// Top level of the shortest covering window finder.
//
//  Channel   Direction  Handshake          Payload
//  s_*       in         s_tvalid/s_tready  s_tdata = value, s_tlast = last
//  m_*       out        m_tvalid/m_tready  m_tuser = found, m_tdata = min_length
//  cfg_*     in         cfg_we             cfg_wdata = cover_count
//
// An item passes the back-end states dequeue, window write, count update and check.
// Every entry retired from the front of the window passes a window read and, where it
// counts, a count read and a count write before the next check; a full window retires
// its oldest entry before the write, and a last item adds a result state. Each count
// update is skipped where the value is zero or above k. The window store and the count
// table are read through registers. Reset and every cover_count write clear the sequence state.
// A 4-deep queue takes items while the back end works and drops s_tready only when full;
// a stalled result holds in the output register and blocks only the next result.
`default_nettype none
module min_window_covering_values (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,   // cover_count
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,     // [15:0] value
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,     // [12:0] min_length, [15:13] zero
    output logic             m_tuser      // [0] found
);
    import mwcv_pkg::*;

    item_t            front_item;
    item_t            q_item;
    logic [K_W-1:0]   k_eff;
    logic             q_valid;
    logic             q_ready;
    logic             out_found;
    logic [OCC_W-1:0] out_len;

    mwcv_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_value  (s_tdata),
        .in_last   (s_tlast),
        .item      (front_item),
        .k_eff     (k_eff)
    );

    mwcv_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (front_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    mwcv_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .k_eff     (k_eff),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_found (out_found),
        .out_len   (out_len)
    );

    assign m_tdata = OUT_W'(out_len);
    assign m_tuser = out_found;

endmodule
`default_nettype wire

// ===== rtl/core/mwcv_front.sv =====
// Front end: cover count register and classification of incoming values.
`default_nettype none
module mwcv_front (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic [mwcv_pkg::K_W-1:0]    cfg_wdata,
    input  wire logic [mwcv_pkg::VALUE_W-1:0] in_value,
    input  wire logic                        in_last,
    output mwcv_pkg::item_t                  item,
    output logic [mwcv_pkg::K_W-1:0]         k_eff
);
    import mwcv_pkg::*;

    logic [K_W-1:0] cover_reg;
    logic [K_W-1:0] cover_next;
    logic           in_range;

    // Saturate k into 1..MAX_COVER on the write.
    always_comb begin
        cover_next = cover_reg;
        if (cfg_we) begin
            priority if (cfg_wdata == '0) begin
                cover_next = K_W'(1);
            end else if (cfg_wdata > K_W'(MAX_COVER)) begin
                cover_next = K_W'(MAX_COVER);
            end else begin
                cover_next = cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cover_reg <= K_W'(1);
        end else begin
            cover_reg <= cover_next;
        end
    end

    assign k_eff    = cover_reg;
    assign in_range = (in_value != '0) && (in_value <= VALUE_W'(cover_reg));

    always_comb begin
        item.last           = in_last;
        item.entry.in_range = in_range;
        item.entry.idx      = IDX_W'(in_value - VALUE_W'(1));
    end

endmodule
`default_nettype wire

// ===== rtl/core/mwcv_queue.sv =====
// Short queue of classified items between front and back end.
`default_nettype none
module mwcv_queue (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire mwcv_pkg::item_t in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output mwcv_pkg::item_t out_item
);
    import mwcv_pkg::*;

    item_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg;
    logic [QPTR_W-1:0]   wptr_next;
    logic [QPTR_W-1:0]   rptr_reg;
    logic [QPTR_W-1:0]   rptr_next;
    logic [QPTR_W:0]     fill_reg;
    logic [QPTR_W:0]     fill_next;
    logic                push;
    logic                pop;

    assign in_ready  = (fill_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_item  = slot_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wptr_next = push ? wptr_reg + QPTR_W'(1) : wptr_reg;
        rptr_next = pop  ? rptr_reg + QPTR_W'(1) : rptr_reg;
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + (QPTR_W+1)'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/mwcv_back.sv =====
// Back end: window store, value counts and the shrink loop with result register.
`default_nettype none
module mwcv_back (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_we,
    input  wire logic [mwcv_pkg::K_W-1:0]  k_eff,
    input  wire logic                      q_valid,
    output logic                           q_ready,
    input  wire mwcv_pkg::item_t           q_item,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           out_found,
    output logic [mwcv_pkg::OCC_W-1:0]     out_len
);
    import mwcv_pkg::*;

    localparam logic [OCC_W-1:0] BEST_NONE = OCC_W'(WINDOW_DEPTH + 1);
    localparam logic [OCC_W-1:0] OCC_FULL  = OCC_W'(WINDOW_DEPTH);

    back_state_t           state_reg, state_next;
    item_t                 cur_reg, cur_next;
    logic                  pre_reg, pre_next;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [PTR_W-1:0]      tail_reg, tail_next;
    logic [OCC_W-1:0]      occ_reg, occ_next;
    logic [K_W-1:0]        distinct_reg, distinct_next;
    logic [OCC_W-1:0]      best_reg, best_next;
    logic [MAX_COVER-1:0]  valid_reg, valid_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_found_reg, out_found_next;
    logic [OCC_W-1:0]      out_len_reg, out_len_next;

    win_entry_t            win_mem [WINDOW_DEPTH];
    win_entry_t            win_q_reg;
    logic                  win_we;
    logic                  win_re;

    logic [CNT_W-1:0]      cnt_mem [MAX_COVER];
    logic [CNT_W-1:0]      cnt_q_reg;
    logic                  cnt_vld_q_reg;
    logic                  cnt_re;
    logic [IDX_W-1:0]      cnt_raddr;
    logic                  cnt_we;
    logic [IDX_W-1:0]      cnt_waddr;
    logic [CNT_W-1:0]      cnt_wdata;
    logic [CNT_W-1:0]      cnt_val;
    logic                  found;

    // A slot never written since the last clear reads as zero.
    assign cnt_val = cnt_vld_q_reg ? cnt_q_reg : '0;
    assign found   = (best_reg <= OCC_FULL);
    assign q_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        pre_next       = pre_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        occ_next       = occ_reg;
        distinct_next  = distinct_reg;
        best_next      = best_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_len_next   = out_len_reg;
        win_we         = 1'b0;
        win_re         = 1'b0;
        cnt_re         = 1'b0;
        cnt_raddr      = cur_reg.entry.idx;
        cnt_we         = 1'b0;
        cnt_waddr      = cur_reg.entry.idx;
        cnt_wdata      = cnt_val + CNT_W'(1);

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    cur_next = q_item;
                    // Drop the oldest entry first when the window is full.
                    if (occ_reg == OCC_FULL) begin
                        pre_next   = 1'b1;
                        state_next = S_POP_RD;
                    end else begin
                        state_next = S_PUSH;
                    end
                end
            end
            S_POP_RD: begin
                win_re     = 1'b1;
                state_next = S_POP_CNT;
            end
            S_POP_CNT: begin
                head_next = head_reg + PTR_W'(1);
                occ_next  = occ_reg - OCC_W'(1);
                if (win_q_reg.in_range) begin
                    cnt_re     = 1'b1;
                    cnt_raddr  = win_q_reg.idx;
                    state_next = S_POP_WR;
                end else begin
                    pre_next   = 1'b0;
                    state_next = pre_reg ? S_PUSH : S_CHECK;
                end
            end
            S_POP_WR: begin
                cnt_waddr = win_q_reg.idx;
                cnt_wdata = cnt_val - CNT_W'(1);
                if (cnt_val != '0) begin
                    cnt_we = 1'b1;
                    if (cnt_val == CNT_W'(1) && distinct_reg != '0) begin
                        distinct_next = distinct_reg - K_W'(1);
                    end
                end
                pre_next   = 1'b0;
                state_next = pre_reg ? S_PUSH : S_CHECK;
            end
            S_PUSH: begin
                win_we    = 1'b1;
                tail_next = tail_reg + PTR_W'(1);
                occ_next  = occ_reg + OCC_W'(1);
                if (cur_reg.entry.in_range) begin
                    cnt_re     = 1'b1;
                    state_next = S_PUSH_WR;
                end else begin
                    state_next = S_CHECK;
                end
            end
            S_PUSH_WR: begin
                cnt_we = 1'b1;
                if (cnt_val == '0) begin
                    distinct_next = distinct_reg + K_W'(1);
                end
                state_next = S_CHECK;
            end
            S_CHECK: begin
                // Shrink from the front while every value is still covered.
                priority if (distinct_reg == k_eff && occ_reg != '0) begin
                    if (occ_reg < best_reg) begin
                        best_next = occ_reg;
                    end
                    state_next = S_POP_RD;
                end else if (cur_reg.last) begin
                    state_next = S_REPORT;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_REPORT: begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next = 1'b1;
                    out_found_next = found;
                    out_len_next   = found ? best_reg : '0;
                    valid_next     = '0;
                    distinct_next  = '0;
                    head_next      = '0;
                    tail_next      = '0;
                    occ_next       = '0;
                    best_next      = BEST_NONE;
                    state_next     = S_IDLE;
                end
            end
        endcase

        if (cnt_we) begin
            valid_next[cnt_waddr] = 1'b1;
        end

        // A new k restarts the sequence.
        if (cfg_we) begin
            valid_next    = '0;
            distinct_next = '0;
            head_next     = '0;
            tail_next     = '0;
            occ_next      = '0;
            best_next     = BEST_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            pre_reg       <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            distinct_reg  <= '0;
            best_reg      <= BEST_NONE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pre_reg       <= pre_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            distinct_reg  <= distinct_next;
            best_reg      <= best_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        out_found_reg <= out_found_next;
        out_len_reg   <= out_len_next;
    end

    always_ff @(posedge aclk) begin
        if (win_we) begin
            win_mem[tail_reg] <= cur_reg.entry;
        end
        if (win_re) begin
            win_q_reg <= win_mem[head_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re) begin
            cnt_q_reg     <= cnt_mem[cnt_raddr];
            cnt_vld_q_reg <= valid_reg[cnt_raddr];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_found = out_found_reg;
    assign out_len   = out_len_reg;

endmodule
`default_nettype wire

// ===== rtl/core/mwcv_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module mwcv_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [mwcv_pkg::OUT_W-1:0]   m_tdata,
    input wire logic                         m_tuser
);
    import mwcv_pkg::*;

    `MWCV_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid, "result valid after reset")
    `MWCV_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `MWCV_ASSERT(a_none_zero, aclk, aresetn, m_tvalid && !m_tuser |-> m_tdata == '0, "length nonzero without a cover")
    `MWCV_ASSERT(a_found_range, aclk, aresetn, m_tvalid && m_tuser |-> m_tdata != '0 && m_tdata <= OUT_W'(WINDOW_DEPTH), "covering length out of range")

endmodule

bind min_window_covering_values mwcv_checker u_mwcv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// ===== test/min_window_covering_values_test.sv =====
// Self-checking testbench for the shortest covering window finder.
`timescale 1ns / 100ps

module min_window_covering_values_test;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 64;
    localparam int unsigned RANDOM_ITEMS  = 1400;
    localparam int unsigned QUIET_ITEMS   = 150;
    localparam int unsigned COVER_MAX     = mwcv_pkg::MAX_COVER;
    localparam int unsigned DEPTH         = mwcv_pkg::WINDOW_DEPTH;

    typedef struct packed {
        logic        found;
        logic [12:0] min_length;
    } cover_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;      // [15:0] value
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;             // [12:0] min_length, [15:13] zero
    logic        m_tuser;             // [0] found

    // Predicted block state
    logic [7:0]   cover_setting = 8'd1;
    int unsigned  value_tally [1:COVER_MAX];
    int unsigned  present_values;
    logic [15:0]  window_q [$];
    int unsigned  shortest_len;

    cover_result_t pending_covers [$];
    logic [15:0]   seq_buf [$];

    bit          idle_on = 1'b1;
    int unsigned hold_off_cycles = 0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;
    int unsigned failures = 0;

    min_window_covering_values uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #2 aclk = ~aclk;

    function automatic int unsigned active_cover();
        int unsigned k = cover_setting;
        if (k == 0) k = 1;
        if (k > COVER_MAX) k = COVER_MAX;
        return k;
    endfunction

    function automatic void clear_sequence();
        foreach (value_tally[i]) value_tally[i] = 0;
        present_values = 0;
        window_q.delete();
        shortest_len = DEPTH + 1;
    endfunction

    function automatic void retire_oldest(int unsigned k);
        logic [15:0] v;
        if (window_q.size() == 0) return;
        v = window_q.pop_front();
        if (v >= 1 && v <= k && value_tally[v] != 0) begin
            value_tally[v]--;
            if (value_tally[v] == 0 && present_values != 0) present_values--;
        end
    endfunction

    function automatic void predict_cover(logic [15:0] v, logic lst);
        int unsigned k = active_cover();
        cover_result_t res;
        // full window: drop the oldest entry before the push
        if (window_q.size() >= DEPTH) retire_oldest(k);
        window_q.push_back(v);
        if (v >= 1 && v <= k) begin
            value_tally[v]++;
            if (value_tally[v] == 1) present_values++;
        end
        while (present_values == k && window_q.size() != 0) begin
            if (window_q.size() < shortest_len) shortest_len = window_q.size();
            retire_oldest(k);
        end
        if (lst) begin
            res = '0;
            if (shortest_len <= DEPTH) begin
                res.found = 1'b1;
                res.min_length = 13'(shortest_len);
            end
            pending_covers.push_back(res);
            clear_sequence();
        end
    endfunction

    // Result checker
    always @(posedge aclk) begin
        cover_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_covers.size() == 0) begin
                $error("unexpected result: found %0d, min_length %0d", m_tuser, m_tdata[12:0]);
                failures++;
            end else begin
                want = pending_covers.pop_front();
                if (m_tuser !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, m_tuser);
                    failures++;
                end
                if (m_tdata[12:0] !== want.min_length) begin
                    $error("min_length: expected %0d, got %0d", want.min_length,
                           m_tdata[12:0]);
                    failures++;
                end
            end
        end
    end

    // Receiver: long hold-off on request, else random stall bursts
    always @(posedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_item(input logic [15:0] v, input logic lst);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_cover(v, lst);
    endtask

    // Hold the sender until every pending result is back, then let the back end settle
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_covers.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_cover_count(input logic [7:0] k);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= k;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cover_setting = k;
        clear_sequence();
    endtask

    function automatic logic [15:0] noise_value(int unsigned k);
        case ($urandom_range(0, 2))
            0: return 16'd0;
            1: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(k + 1, 65535));
        endcase
    endfunction

    function automatic logic [7:0] pick_cover_count();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'($urandom_range(1, 4));
            4, 5, 6: return 8'($urandom_range(5, 16));
            7: return 8'($urandom_range(17, 127));
            8: return ($urandom_range(0, 1) != 0) ? 8'(COVER_MAX) : 8'($urandom_range(129, 255));
            default: return 8'd0;
        endcase
    endfunction

    // Random fill, mostly with a scrambled full set of 1..k (sometimes one value short)
    function automatic void build_sequence();
        int unsigned k = active_cover();
        int unsigned kind = $urandom_range(0, 9);
        int unsigned fill = $urandom_range(0, k + 6);
        int unsigned skip = 0;
        seq_buf.delete();
        for (int unsigned i = 0; i < fill; i++) begin
            if ($urandom_range(0, 4) != 0) seq_buf.push_back(16'($urandom_range(1, k)));
            else seq_buf.push_back(noise_value(k));
        end
        if (kind <= 6 || kind == 9) begin
            if (kind == 9) skip = $urandom_range(1, k);
            for (int unsigned v = 1; v <= k; v++) begin
                if (v != skip) seq_buf.insert($urandom_range(0, seq_buf.size()), 16'(v));
            end
        end
        if (seq_buf.size() == 0) seq_buf.push_back(noise_value(k));
    endfunction

    task automatic send_sequence();
        foreach (seq_buf[i]) send_item(seq_buf[i], i == seq_buf.size() - 1);
    endtask

    task automatic run_sequences(input int unsigned item_goal);
        int unsigned sent = 0;
        while (sent < item_goal) begin
            if ($urandom_range(0, 5) == 0) set_cover_count(pick_cover_count());
            if ($urandom_range(0, 7) == 0) wait_for_results();
            build_sequence();
            sent += seq_buf.size();
            send_sequence();
        end
    endtask

    task automatic test_reset_cover();
        // cover_count still at its reset value of one
        send_item(16'd0, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'd1, 1'b1);
        send_item(16'd5, 1'b1);
    endtask

    task automatic test_cover_limits();
        set_cover_count(8'd0);
        send_item(16'd1, 1'b0);
        send_item(16'd1, 1'b1);
        set_cover_count(8'd255);
        send_item(16'd128, 1'b0);
        send_item(16'd129, 1'b1);
        set_cover_count(8'd3);
        send_item(16'd3, 1'b0);
        send_item(16'd1, 1'b0);
        send_item(16'd1, 1'b0);
        send_item(16'd2, 1'b0);
        send_item(16'h8000, 1'b0);
        send_item(16'd3, 1'b0);
        send_item(16'd1, 1'b0);
        send_item(16'd2, 1'b1);
    endtask

    task automatic test_config_clears();
        set_cover_count(8'd2);
        send_item(16'd1, 1'b0);
        // rewrite drops the pending 1, so the 2 alone does not cover
        set_cover_count(8'd2);
        send_item(16'd2, 1'b1);
    endtask

    task automatic test_cover_128();
        set_cover_count(8'(COVER_MAX));
        build_sequence();
        send_sequence();
    endtask

    function automatic logic [15:0] window_filler();
        return ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(3, 65535));
    endfunction

    task automatic test_full_window();
        set_cover_count(8'd2);
        // cover exactly as long as the window store
        send_item(16'd1, 1'b0);
        for (int i = 0; i < DEPTH - 2; i++) send_item(window_filler(), 1'b0);
        send_item(16'd2, 1'b1);
        // one longer: the leading 1 is pushed out
        send_item(16'd1, 1'b0);
        for (int i = 0; i < DEPTH - 1; i++) send_item(window_filler(), 1'b0);
        send_item(16'd2, 1'b1);
    endtask

    task automatic test_backpressure();
        set_cover_count(8'd1);
        hold_off_cycles = 300;
        for (int i = 0; i < 24; i++) send_item(16'($urandom_range(0, 1)), 1'b1);
        wait_for_results();
    endtask

    task automatic test_random_sequences();
        run_sequences(RANDOM_ITEMS);
    endtask

    task automatic test_quiet_tail();
        idle_on = 1'b0;
        set_cover_count(8'd4);
        run_sequences(QUIET_ITEMS);
    endtask

    initial begin
        clear_sequence();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_cover();
        test_cover_limits();
        test_config_clears();
        test_cover_128();
        test_backpressure();
        test_full_window();
        test_random_sequences();
        test_quiet_tail();

        wait_for_results();
        if (failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/mwcv_pkg.sv
rtl/core/mwcv_front.sv
rtl/core/mwcv_queue.sv
rtl/core/mwcv_back.sv
rtl/core/min_window_covering_values.sv
rtl/core/mwcv_checker.sv
test/min_window_covering_values_test.sv
